/* src/esrb_pkg.sv */
package esrb_pkg;

	// operation codes on the op field
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_FINISH  = 1'b1;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_ACCEPTED = 2'd0;
	localparam status_t ST_AT_START = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_ROUTE    = 2'd3;

endpackage

/* src/elevator_scan_route_builder.sv */
// channel   dir  handshake            payload
// ------    ---  -------------------  ----------------------------------
// config    in   cfg_we               cfg_wdata (start floor)
// request   in   in_valid / in_ready  op, floor
// result    out  out_valid / out_ready route_floor, status, last
//
// a request into an empty store is written directly; otherwise the sorted
// insertion reads and shifts up each stored stop it moves past, then writes
// the new floor, and the result waits for the output register.
// a finish emits the start floor, then reads and emits each stored stop;
// the pace is set by the single read port and registered read data of the
// stop memories. in_ready is high only between items.
// arst_n clears counts, direction and the start floor; stop memories are not
// cleared. a stalled out_ready holds the result register and the sequencer.
module elevator_scan_route_builder #(
	parameter int MAX_REQUESTS = 31,
	parameter int FLOOR_BITS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [FLOOR_BITS-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  op,
	input  logic [FLOOR_BITS-1:0] floor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FLOOR_BITS-1:0] route_floor,
	output esrb_pkg::status_t     status,
	output logic                  last
);
	import esrb_pkg::*;

	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_FIN,
		S_RESULT,
		S_EM_START,
		S_EM_RD,
		S_EM_LD
	} state_t;

	state_t                state_q;
	logic [FLOOR_BITS-1:0] start_q;
	logic [CNT_W-1:0]      swp_cnt_q;
	logic [CNT_W-1:0]      ret_cnt_q;
	logic                  going_up_q;
	logic                  dir_fixed_q;
	logic                  sel_ret_q;
	logic                  asc_q;
	logic [FLOOR_BITS-1:0] f_q;
	logic [IDX_W-1:0]      pos_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  emit_ret_q;
	status_t               res_status_q;

	logic                  out_valid_q;
	logic [FLOOR_BITS-1:0] route_floor_q;
	status_t               status_q;
	logic                  last_q;

	// stop memories and their registered read data
	logic [FLOOR_BITS-1:0] swp_mem [MAX_REQUESTS];
	logic [FLOOR_BITS-1:0] ret_mem [MAX_REQUESTS];
	logic [FLOOR_BITS-1:0] swp_rd_q;
	logic [FLOOR_BITS-1:0] ret_rd_q;

	logic                  mem_we;
	logic                  mem_sel;
	logic [IDX_W-1:0]      mem_waddr;
	logic [FLOOR_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;

	logic                  in_fire;
	logic                  out_free;
	logic                  out_load;
	logic                  is_up;
	logic                  to_ret;
	logic [CNT_W-1:0]      ins_cnt;
	logic [CNT_W:0]        used;
	logic                  full;
	logic                  insert_ok;
	logic [FLOOR_BITS-1:0] prev;
	logic                  after;
	logic [CNT_W-1:0]      cur_cnt;
	logic                  idx_end;
	logic                  is_last;
	logic [FLOOR_BITS-1:0] emit_data;

	assign in_ready    = (state_q == S_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign route_floor = route_floor_q;
	assign status      = status_q;
	assign last        = last_q;

	// result register loads a new beat this cycle
	assign out_load = out_free &&
		(state_q == S_RESULT || state_q == S_EM_START || state_q == S_EM_LD);

	// request classification against the start floor
	assign is_up     = dir_fixed_q ? going_up_q : (floor > start_q);
	assign to_ret    = is_up ? (floor < start_q) : (floor > start_q);
	assign ins_cnt   = to_ret ? ret_cnt_q : swp_cnt_q;
	assign used      = {1'b0, swp_cnt_q} + {1'b0, ret_cnt_q};
	assign full      = used >= (CNT_W+1)'(MAX_REQUESTS);
	assign insert_ok = (floor != start_q) && !full;

	// insertion compare on the entry just read
	assign prev  = sel_ret_q ? ret_rd_q : swp_rd_q;
	assign after = asc_q ? (prev > f_q) : (prev < f_q);

	// emission bookkeeping
	assign cur_cnt   = emit_ret_q ? ret_cnt_q : swp_cnt_q;
	assign idx_end   = (CNT_W'(idx_q) + CNT_W'(1)) == cur_cnt;
	assign is_last   = idx_end && (emit_ret_q || (ret_cnt_q == '0));
	assign emit_data = emit_ret_q ? ret_rd_q : swp_rd_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_sel   = sel_ret_q;
		mem_waddr = pos_q;
		mem_wdata = f_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		unique case (state_q)
			S_IDLE: begin
				mem_sel = to_ret;
				if (in_fire && op == OP_REQUEST && insert_ok) begin
					if (ins_cnt == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = floor;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ins_cnt[IDX_W-1:0] - IDX_W'(1);
					end
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				if (after) begin
					mem_wdata = prev;
					if (pos_q > IDX_W'(1)) begin
						mem_re    = 1'b1;
						mem_raddr = pos_q - IDX_W'(2);
					end
				end
			end
			S_INS_FIN: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end
			S_EM_RD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// stop memories, one write and one read port each
	always_ff @(posedge clk) begin
		if (mem_we && !mem_sel) begin
			swp_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_we && mem_sel) begin
			ret_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			swp_rd_q <= swp_mem[mem_raddr];
			ret_rd_q <= ret_mem[mem_raddr];
		end
	end

	// sequencer, route state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			start_q       <= '0;
			swp_cnt_q     <= '0;
			ret_cnt_q     <= '0;
			going_up_q    <= 1'b0;
			dir_fixed_q   <= 1'b0;
			sel_ret_q     <= 1'b0;
			asc_q         <= 1'b0;
			f_q           <= '0;
			pos_q         <= '0;
			idx_q         <= '0;
			emit_ret_q    <= 1'b0;
			res_status_q  <= ST_ACCEPTED;
			out_valid_q   <= 1'b0;
			route_floor_q <= '0;
			status_q      <= ST_ACCEPTED;
			last_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (op == OP_FINISH) begin
							state_q <= S_EM_START;
						end else if (floor == start_q) begin
							res_status_q <= ST_AT_START;
							state_q      <= S_RESULT;
						end else if (full) begin
							res_status_q <= ST_FULL;
							state_q      <= S_RESULT;
						end else begin
							going_up_q   <= is_up;
							dir_fixed_q  <= 1'b1;
							sel_ret_q    <= to_ret;
							asc_q        <= is_up ^ to_ret;
							f_q          <= floor;
							pos_q        <= ins_cnt[IDX_W-1:0];
							res_status_q <= ST_ACCEPTED;
							if (ins_cnt == '0) begin
								if (to_ret) begin
									ret_cnt_q <= ret_cnt_q + CNT_W'(1);
								end else begin
									swp_cnt_q <= swp_cnt_q + CNT_W'(1);
								end
								state_q <= S_RESULT;
							end else begin
								state_q <= S_INS_CMP;
							end
						end
					end
				end
				S_INS_CMP: begin
					if (after) begin
						pos_q <= pos_q - IDX_W'(1);
						if (pos_q == IDX_W'(1)) begin
							state_q <= S_INS_FIN;
						end
					end else begin
						if (sel_ret_q) begin
							ret_cnt_q <= ret_cnt_q + CNT_W'(1);
						end else begin
							swp_cnt_q <= swp_cnt_q + CNT_W'(1);
						end
						state_q <= S_RESULT;
					end
				end
				S_INS_FIN: begin
					if (sel_ret_q) begin
						ret_cnt_q <= ret_cnt_q + CNT_W'(1);
					end else begin
						swp_cnt_q <= swp_cnt_q + CNT_W'(1);
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						route_floor_q <= '0;
						status_q      <= res_status_q;
						last_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_EM_START: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						route_floor_q <= start_q;
						status_q      <= ST_ROUTE;
						last_q        <= (used == '0);
						idx_q         <= '0;
						emit_ret_q    <= (swp_cnt_q == '0);
						if (used == '0) begin
							going_up_q  <= 1'b0;
							dir_fixed_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_EM_RD;
						end
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_LD;
				end
				S_EM_LD: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						route_floor_q <= emit_data;
						status_q      <= ST_ROUTE;
						last_q        <= is_last;
						if (is_last) begin
							swp_cnt_q   <= '0;
							ret_cnt_q   <= '0;
							going_up_q  <= 1'b0;
							dir_fixed_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							if (idx_end) begin
								emit_ret_q <= 1'b1;
								idx_q      <= '0;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
							state_q <= S_EM_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// both stores together never hold more than the request limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		used <= (CNT_W+1)'(MAX_REQUESTS))
		else $error("stop counts exceed request limit");

	// the shifting insertion always has an entry below the write position
	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_CMP |-> pos_q != '0)
		else $error("insertion compare at position zero");

	// stops are never stored without a fixed direction
	a_dir_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!dir_fixed_q |-> (swp_cnt_q == '0 && ret_cnt_q == '0))
		else $error("stops stored without a fixed direction");

endmodule
